// ===== design/pcrl_pkg.sv =====
package pcrl_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned AddrW = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CoolW = 16;
  localparam int unsigned EntryW = 2 * AddrW + TimeW;
  localparam logic [CoolW-1:0] CooldownReset = CoolW'(1000);

  typedef enum logic [2:0] {
    OutDenied = 3'd0,
    OutKnown  = 3'd1,
    OutFree   = 3'd2,
    OutStale  = 3'd3,
    OutFull   = 3'd4
  } outcome_e;

  typedef struct packed {
    logic [AddrW-1:0] nb;
    logic [AddrW-1:0] dst;
    logic [TimeW-1:0] now;
  } req_t;

  typedef struct packed {
    logic     allowed;
    outcome_e outcome;
  } res_t;

endpackage

// ===== design/pair_cooldown_rate_limiter.sv =====
// pair cooldown rate limiter
// requests enter through a queue-style port: a transfer happens when push is
// high and full is low, carrying neighbour address, destination address and
// the current millisecond time. results leave the same way: while empty is
// low, allowed_o and outcome_o show the oldest result, taken when pop is high.
// cooldown is written through cfg_we_i / cfg_wdata_i; the user must write it
// only while idle, the block does not enforce this. a two-entry request queue
// feeds the lookup engine, which scans the pair table one entry per cycle out
// of a ram with one write and one read port and a registered read. one request
// is looked up at a time: the engine takes the next one only after its result
// has left for the result queue.
// reset clears the fill count, both queues and sets cooldown to 1000 ms;
// table contents are not cleared, only filled slots are ever read.
// when pop is held low the result queue fills, the engine waits with its
// result and the request queue then raises full.
module pair_cooldown_rate_limiter import pcrl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [AddrW-1:0] neighbor_address_i,
  input  logic [AddrW-1:0] destination_address_i,
  input  logic [TimeW-1:0] time_ms_i,
  output logic             empty,
  input  logic             pop,
  output logic             allowed_o,
  output logic [2:0]       outcome_o,
  input  logic             cfg_we_i,
  input  logic [CoolW-1:0] cfg_wdata_i
);

  logic [CoolW-1:0] cooldown_q;
  req_t             req_in, req;
  logic             req_valid, req_ready;
  logic             res_valid, res_ready;
  res_t             res, res_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooldown_q <= CooldownReset;
    end else if (cfg_we_i) begin
      cooldown_q <= cfg_wdata_i;
    end
  end

  assign req_in = '{nb: neighbor_address_i, dst: destination_address_i, now: time_ms_i};

  pcrl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .req_i      (req_in),
    .full_o     (full),
    .req_valid_o(req_valid),
    .req_o      (req),
    .req_ready_i(req_ready)
  );

  pcrl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cooldown_i (cooldown_q),
    .req_valid_i(req_valid),
    .req_i      (req),
    .req_ready_o(req_ready),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(res_ready)
  );

  pcrl_resq u_resq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .res_ready_o(res_ready),
    .empty_o    (empty),
    .res_o      (res_head),
    .pop_i      (pop)
  );

  assign allowed_o = res_head.allowed;
  assign outcome_o = res_head.outcome;

endmodule

// ===== design/pcrl_ram.sv =====
module pcrl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== design/pcrl_front.sv =====
module pcrl_front import pcrl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t req_i,
  output logic full_o,
  output logic req_valid_o,
  output req_t req_o,
  input  logic req_ready_i
);

  req_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign full_o      = (cnt_q == 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = slot_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = req_valid_o && req_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= req_i;
    end
  end

endmodule

// ===== design/pcrl_back.sv =====
module pcrl_back import pcrl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CoolW-1:0] cooldown_i,
  input  logic             req_valid_i,
  input  req_t             req_i,
  output logic             req_ready_o,
  output logic             res_valid_o,
  output res_t             res_o,
  input  logic             res_ready_i
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  state_e          state_q;
  req_t            req_q;
  logic [CntW-1:0] used_q;
  logic [CntW-1:0] issue_q;
  logic            cmp_vld_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            have_stale_q;
  logic [IdxW-1:0] stale_idx_q;
  logic            wr_q;
  logic [IdxW-1:0] wr_idx_q;
  res_t            res_q;

  logic             start, more, rd_en, we;
  logic [IdxW-1:0]  rd_addr;
  logic [EntryW-1:0] rdata;
  req_t             entry;
  logic [TimeW-1:0] elapsed;
  logic             hit, stale;

  assign start       = (state_q == StIdle) && req_valid_i;
  assign req_ready_o = start;
  assign more        = issue_q < used_q;
  assign rd_en       = (start && (used_q != '0)) || ((state_q == StScan) && more);
  assign rd_addr     = start ? '0 : issue_q[IdxW-1:0];
  assign res_valid_o = (state_q == StDone);
  assign res_o       = res_q;
  assign we          = res_valid_o && res_ready_i && wr_q;

  assign entry   = req_t'(rdata);
  assign elapsed = req_q.now - entry.now;
  assign hit     = (entry.nb == req_q.nb) && (entry.dst == req_q.dst);
  assign stale   = elapsed >= TimeW'(cooldown_i);

  pcrl_ram #(
    .Width(EntryW),
    .Depth(TableEntries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wr_idx_q),
    .wdata_i(req_q),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      used_q       <= '0;
      issue_q      <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      have_stale_q <= 1'b0;
      stale_idx_q  <= '0;
      wr_q         <= 1'b0;
      wr_idx_q     <= '0;
      res_q        <= '{allowed: 1'b0, outcome: OutDenied};
      req_q        <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (req_valid_i) begin
            req_q <= req_i;
            if (used_q == '0) begin
              res_q    <= '{allowed: 1'b1, outcome: OutFree};
              wr_q     <= 1'b1;
              wr_idx_q <= '0;
              state_q  <= StDone;
            end else begin
              issue_q      <= CntW'(1);
              cmp_vld_q    <= 1'b1;
              cmp_idx_q    <= '0;
              have_stale_q <= 1'b0;
              state_q      <= StScan;
            end
          end
        end
        StScan: begin
          if (cmp_vld_q && hit) begin
            if (!stale) begin
              res_q <= '{allowed: 1'b0, outcome: OutDenied};
              wr_q  <= 1'b0;
            end else begin
              res_q    <= '{allowed: 1'b1, outcome: OutKnown};
              wr_q     <= 1'b1;
              wr_idx_q <= cmp_idx_q;
            end
            state_q <= StDone;
          end else if (cmp_vld_q) begin
            if (!have_stale_q && stale) begin
              have_stale_q <= 1'b1;
              stale_idx_q  <= cmp_idx_q;
            end
            cmp_vld_q <= more;
            cmp_idx_q <= issue_q[IdxW-1:0];
            if (more) begin
              issue_q <= issue_q + CntW'(1);
            end
          end else begin
            // scan finished without a match
            if (used_q < CntW'(TableEntries)) begin
              res_q    <= '{allowed: 1'b1, outcome: OutFree};
              wr_q     <= 1'b1;
              wr_idx_q <= used_q[IdxW-1:0];
            end else if (have_stale_q) begin
              res_q    <= '{allowed: 1'b1, outcome: OutStale};
              wr_q     <= 1'b1;
              wr_idx_q <= stale_idx_q;
            end else begin
              res_q <= '{allowed: 1'b1, outcome: OutFull};
              wr_q  <= 1'b0;
            end
            state_q <= StDone;
          end
        end
        StDone: begin
          if (res_ready_i) begin
            if (res_q.outcome == OutFree) begin
              used_q <= used_q + CntW'(1);
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== design/pcrl_resq.sv =====
module pcrl_resq import pcrl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  input  res_t res_i,
  output logic res_ready_o,
  output logic empty_o,
  output res_t res_o,
  input  logic pop_i
);

  res_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign res_ready_o = (cnt_q != 2'd2);
  assign empty_o     = (cnt_q == 2'd0);
  assign res_o       = slot_q[rd_ptr_q];
  assign wr_en       = res_valid_i && res_ready_o;
  assign rd_en       = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

// ===== design/pcrl_checker.sv =====
module pcrl_checker import pcrl_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             push,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic             allowed_o,
  input logic [2:0]       outcome_o
);

  a_allowed_matches_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (allowed_o == (outcome_o != OutDenied)))
    else $error("allowed disagrees with outcome");

  a_outcome_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (outcome_o <= OutFull))
    else $error("outcome out of range");

  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without a request transfer");

  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(allowed_o) && $stable(outcome_o)))
    else $error("waiting result changed");

endmodule

bind pair_cooldown_rate_limiter pcrl_checker u_pcrl_checker (.*);

// ===== tb/tb_pair_cooldown_rate_limiter.sv =====
`timescale 1ns / 100ps

module tb_pair_cooldown_rate_limiter;
  import pcrl_pkg::*;

  localparam int unsigned SettleCycles = 24;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned PlanRows = 18;

  typedef enum logic {
    RowReq,
    RowCool
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [AddrW-1:0] nb;
    logic [AddrW-1:0] dst;
    logic [TimeW-1:0] now;
    logic [7:0]       reps;
    logic             typed;
    res_t             want;
    logic [CoolW-1:0] cool;
  } row_t;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             full;
  logic [AddrW-1:0] neighbor_address = '0;
  logic [AddrW-1:0] destination_address = '0;
  logic [TimeW-1:0] time_ms = '0;
  logic             empty;
  logic             pop = 1'b0;
  logic             allowed;
  logic [2:0]       outcome;
  logic             cfg_we = 1'b0;
  logic [CoolW-1:0] cfg_wdata = '0;

  // fixed expectation travelling with the request being offered
  logic             fixed_valid = 1'b0;
  res_t             fixed_verdict = '0;

  // predictor state
  logic [AddrW-1:0] tbl_nb [TableEntries];
  logic [AddrW-1:0] tbl_dst [TableEntries];
  logic [TimeW-1:0] tbl_time [TableEntries];
  int unsigned      fill_cnt;
  logic [CoolW-1:0] cool_ms;

  res_t        verdict_q [$];
  res_t        want_v;
  res_t        got_v;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold = 0;

  row_t plan [PlanRows] = '{
    '{RowReq,  32'h0000_0000, 32'h0000_0000, 32'd0,         8'd1,  1'b1, '{1'b1, OutFree},   16'd0},
    '{RowReq,  32'h0000_0000, 32'h0000_0000, 32'd999,       8'd1,  1'b1, '{1'b0, OutDenied}, 16'd0},
    '{RowReq,  32'h0000_0000, 32'h0000_0000, 32'd1000,      8'd1,  1'b1, '{1'b1, OutKnown},  16'd0},
    '{RowReq,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1,  1'b1, '{1'b1, OutFree},   16'd0},
    '{RowReq,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,         8'd1,  1'b1, '{1'b0, OutDenied}, 16'd0},
    '{RowReq,  32'h0000_0000, 32'h0000_0000, 32'd500,       8'd1,  1'b1, '{1'b1, OutKnown},  16'd0},
    '{RowReq,  32'h0000_0000, 32'hFFFF_FFFF, 32'd10,        8'd1,  1'b1, '{1'b1, OutFree},   16'd0},
    '{RowReq,  32'hFFFF_FFFF, 32'h0000_0000, 32'd10,        8'd1,  1'b1, '{1'b1, OutFree},   16'd0},
    '{RowCool, 32'h0,         32'h0,         32'd0,         8'd0,  1'b0, '{1'b0, OutDenied}, 16'd0},
    '{RowReq,  32'h0000_0000, 32'h0000_0000, 32'd500,       8'd1,  1'b1, '{1'b1, OutKnown},  16'd0},
    '{RowReq,  32'h0000_0100, 32'h0000_0001, 32'd2000,      8'd12, 1'b1, '{1'b1, OutFree},   16'd0},
    '{RowCool, 32'h0,         32'h0,         32'd0,         8'd0,  1'b0, '{1'b0, OutDenied}, 16'hFFFF},
    '{RowReq,  32'h0000_0200, 32'h0000_0001, 32'd2001,      8'd1,  1'b1, '{1'b1, OutFull},   16'd0},
    '{RowReq,  32'h0000_0100, 32'h0000_0001, 32'd2001,      8'd1,  1'b1, '{1'b0, OutDenied}, 16'd0},
    '{RowCool, 32'h0,         32'h0,         32'd0,         8'd0,  1'b0, '{1'b0, OutDenied}, 16'd1000},
    '{RowReq,  32'h0000_0300, 32'h0000_0001, 32'd2600,      8'd1,  1'b1, '{1'b1, OutStale},  16'd0},
    '{RowReq,  32'h0000_0000, 32'h0000_0000, 32'd2600,      8'd1,  1'b0, '{1'b0, OutDenied}, 16'd0},
    '{RowReq,  32'h0000_010B, 32'h0000_0001, 32'd3000,      8'd1,  1'b0, '{1'b0, OutDenied}, 16'd0}
  };

  pair_cooldown_rate_limiter dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .push                  (push),
    .full                  (full),
    .neighbor_address_i    (neighbor_address),
    .destination_address_i (destination_address),
    .time_ms_i             (time_ms),
    .empty                 (empty),
    .pop                   (pop),
    .allowed_o             (allowed),
    .outcome_o             (outcome),
    .cfg_we_i              (cfg_we),
    .cfg_wdata_i           (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic res_t judge_request(input logic [AddrW-1:0] nb,
                                         input logic [AddrW-1:0] dst,
                                         input logic [TimeW-1:0] now);
    res_t             r;
    logic [TimeW-1:0] gap;
    int               stale_idx;
    stale_idx = -1;
    for (int i = 0; i < int'(fill_cnt); i++) begin
      gap = now - tbl_time[i];
      if (tbl_nb[i] == nb && tbl_dst[i] == dst) begin
        if (gap < TimeW'(cool_ms)) begin
          r.allowed = 1'b0;
          r.outcome = OutDenied;
        end else begin
          tbl_time[i] = now;
          r.allowed = 1'b1;
          r.outcome = OutKnown;
        end
        return r;
      end
      if (stale_idx < 0 && gap >= TimeW'(cool_ms)) stale_idx = i;
    end
    r.allowed = 1'b1;
    if (fill_cnt < TableEntries) begin
      tbl_nb[fill_cnt] = nb;
      tbl_dst[fill_cnt] = dst;
      tbl_time[fill_cnt] = now;
      fill_cnt++;
      r.outcome = OutFree;
    end else if (stale_idx >= 0) begin
      tbl_nb[stale_idx] = nb;
      tbl_dst[stale_idx] = dst;
      tbl_time[stale_idx] = now;
      r.outcome = OutStale;
    end else begin
      r.outcome = OutFull;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request pending, expected none, actual %0b/%0d",
                   $time, allowed, outcome);
        end else begin
          want_v = verdict_q.pop_front();
          if (allowed !== want_v.allowed) begin
            mismatches++;
            $display("%0t: allowed mismatch, expected %0b, actual %0b",
                     $time, want_v.allowed, allowed);
          end
          if (outcome !== want_v.outcome) begin
            mismatches++;
            $display("%0t: outcome mismatch, expected %0d, actual %0d",
                     $time, want_v.outcome, outcome);
          end
        end
      end
      if (push && !full) begin
        got_v = judge_request(neighbor_address, destination_address, time_ms);
        verdict_q.push_back(fixed_valid ? fixed_verdict : got_v);
      end
      if (cfg_we) cool_ms = cfg_wdata;
    end
  end

  // result side stalls in bursts
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      pop <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      pop <= 1'b0;
      rx_hold <= $urandom_range(1, 19) - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("tb_pair_cooldown_rate_limiter failed");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [AddrW-1:0] nb, input logic [AddrW-1:0] dst,
                              input logic [TimeW-1:0] now, input logic typed,
                              input res_t want);
    push <= 1'b1;
    neighbor_address <= nb;
    destination_address <= dst;
    time_ms <= now;
    fixed_valid <= typed;
    fixed_verdict <= want;
    do @(posedge clk_i); while (full);
  endtask

  task automatic maybe_gap(input int unsigned pct);
    if ($urandom_range(0, 99) < pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic write_cooldown(input logic [CoolW-1:0] value);
    push <= 1'b0;
    do @(negedge clk_i); while (verdict_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned items, input logic [CoolW-1:0] cd,
                              input int unsigned step_max, input int unsigned idle_pct);
    logic [AddrW-1:0] nb_pool [6];
    logic [AddrW-1:0] dst_pool [4];
    logic [AddrW-1:0] nb;
    logic [AddrW-1:0] dst;
    logic [TimeW-1:0] clock_ms;
    rx_stall_pct = idle_pct;
    write_cooldown(cd);
    foreach (nb_pool[k]) nb_pool[k] = $urandom;
    foreach (dst_pool[k]) dst_pool[k] = $urandom;
    clock_ms = $urandom;
    for (int n = 0; n < int'(items); n++) begin
      if ($urandom_range(0, 99) < 10) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      if ($urandom_range(0, 9) == 0) begin
        nb = $urandom;
        dst = $urandom;
      end else begin
        nb = nb_pool[$urandom_range(0, 5)];
        dst = dst_pool[$urandom_range(0, 3)];
      end
      maybe_gap(idle_pct);
      send_request(nb, dst, clock_ms, 1'b0, '0);
    end
  endtask

  initial begin
    logic [CoolW-1:0] cd;
    fill_cnt = 0;
    cool_ms = CooldownReset;
    rx_stall_pct = 20;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < int'(PlanRows); r++) begin
      if (plan[r].kind == RowCool) begin
        write_cooldown(plan[r].cool);
      end else begin
        for (int k = 0; k < int'(plan[r].reps); k++) begin
          maybe_gap(20);
          send_request(plan[r].nb + k, plan[r].dst, plan[r].now, plan[r].typed,
                       plan[r].want);
        end
      end
    end

    random_phase(100, 16'd37, 12, 40);
    random_phase(100, 16'd0, 5, 10);
    random_phase(100, 16'hFFFF, 4000, 40);
    cd = CoolW'($urandom_range(0, 65535));
    random_phase(100, cd, cd / 4 + 1, 0);
    random_phase(100, 16'd1, 2, 40);
    cd = CoolW'($urandom_range(2, 300));
    random_phase(100, cd, cd / 8 + 1, 10);
    cd = CoolW'($urandom_range(0, 65535));
    random_phase(100, cd, cd / 16 + 1, 40);
    random_phase(100, 16'd500, 60, 0);

    push <= 1'b0;
    do @(negedge clk_i); while (verdict_q.size() != 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("tb_pair_cooldown_rate_limiter passed");
    end else begin
      $display("tb_pair_cooldown_rate_limiter failed");
    end
    $finish;
  end

endmodule
